@@ rtl/core/klex_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// klex_pkg - shared types and helpers for the keyword/identifier/number lexer
// Character classes, token kinds, scan modes, and the command and status
// bundles that pass between the lexer controller and its datapath.
// ----------------------------------------------------------------------------
package klex_pkg;

	localparam int MAX_TOKEN_LEN_DEF = 32;

	// token kind codes as carried on the result side
	localparam logic [2:0] KIND_NUM     = 3'd0;
	localparam logic [2:0] KIND_IDENT   = 3'd1;
	localparam logic [2:0] KIND_KEYWORD = 3'd2;
	localparam logic [2:0] KIND_SYMBOL  = 3'd3;
	localparam logic [2:0] KIND_INVALID = 3'd4;

	typedef enum logic [2:0] {
		CLS_DIGIT,
		CLS_ALPHA,
		CLS_UNDER,
		CLS_SPACE,
		CLS_NEWLINE,
		CLS_SYMBOL,
		CLS_OTHER
	} char_class_t;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_NUM,
		MODE_IDENT
	} scan_mode_t;

	typedef struct packed {
		logic use_held;   // operate on the held character instead of the input
		logic capture;    // hold the input word for later
		logic append;     // add the selected character to the token text
		logic clear;      // close the open token
		logic open_num;
		logic open_ident;
		logic idx_clear;  // rewind the text read pointer
		logic idx_inc;
		logic emit_load;  // load the output with the next buffered byte
		logic sym_load;   // load the output with a one-byte symbol or invalid token
		logic run_last;
	} cmd_t;

	typedef struct packed {
		scan_mode_t  mode;
		logic        act;
		char_class_t cls;
		logic        lz;
		logic        last_byte;
		logic        out_free;
	} status_t;

	function automatic char_class_t klex_classify(input logic [7:0] c);
		char_class_t r;
		if (c inside {[8'h30:8'h39]})
			r = CLS_DIGIT;
		else if (c inside {[8'h41:8'h5A], [8'h61:8'h7A]})
			r = CLS_ALPHA;
		else if (c == 8'h5F)
			r = CLS_UNDER;
		else if (c == 8'h0A)
			r = CLS_NEWLINE;
		else if (c inside {8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D})
			r = CLS_SPACE;
		else if (c inside {"+", "-", "*", "=", "(", ")", "{", "}", "<", ">", ";"})
			r = CLS_SYMBOL;
		else
			r = CLS_OTHER;
		return r;
	endfunction

	// keyword spelling checks, one position at a time
	function automatic logic kw_if_at(input logic [2:0] pos, input logic [7:0] c);
		return (pos == 3'd0 && c == "i") || (pos == 3'd1 && c == "f");
	endfunction

	function automatic logic kw_else_at(input logic [2:0] pos, input logic [7:0] c);
		return (pos == 3'd0 && c == "e") || (pos == 3'd1 && c == "l") ||
			(pos == 3'd2 && c == "s") || (pos == 3'd3 && c == "e");
	endfunction

	function automatic logic kw_while_at(input logic [2:0] pos, input logic [7:0] c);
		return (pos == 3'd0 && c == "w") || (pos == 3'd1 && c == "h") ||
			(pos == 3'd2 && c == "i") || (pos == 3'd3 && c == "l") ||
			(pos == 3'd4 && c == "e");
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/keyword_identifier_number_lexer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// keyword_identifier_number_lexer - character stream tokenizer
// Splits a byte stream into number, identifier, keyword, symbol and invalid
// tokens, sending each token's text one byte per output word.
// ----------------------------------------------------------------------------
// One input word is one character, or an end marker (s_tuser high) that
// flushes an open token. A character or end marker that closes a token is
// held while the buffered text is read back from the text memory one byte
// per cycle, while the output is free, through its single registered read
// port; a closing character that is itself a one-byte token is then sent
// as that token. Output backpressure stalls the readout, and a new word is
// taken only in the scan state while the output register is empty or being
// drained, or while halted. Token text beyond MAX_TOKEN_LEN bytes is dropped
// and every byte of that token carries the cut-off flag; a cut identifier is
// never a keyword. A number that starts with '0' directly followed by a digit
// halts the block: all later words are accepted and dropped until reset.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module keyword_identifier_number_lexer #(
	parameter int MAX_TOKEN_LEN = klex_pkg::MAX_TOKEN_LEN_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] char_byte
	input  wire logic       s_tuser,   // [0] action (1 = end of input)
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] text_byte
	output logic [4:0]      m_tuser,   // [2:0] token_kind, [3] run_last, [4] cut_off
	output logic            m_tlast    // token_last
);
	import klex_pkg::*;

	cmd_t    cmd;
	status_t st;

	// controller: per-word decisions and token readout sequencing
	klex_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// datapath: text buffer, token state, output register
	klex_dp #(
		.MAX_TOKEN_LEN (MAX_TOKEN_LEN)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cmd      (cmd),
		.st       (st)
	);

endmodule
`default_nettype wire

@@ rtl/core/klex_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// klex_ctrl - lexer controller
// Decides per input word what the datapath does, and sequences the output
// of a closed token byte by byte.
// ----------------------------------------------------------------------------
module klex_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire klex_pkg::status_t st,
	output klex_pkg::cmd_t         cmd
);
	import klex_pkg::*;

	typedef enum logic [1:0] {
		ST_SCAN,
		ST_EMIT,
		ST_SYM,
		ST_HALT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   tok_open;
	logic   needs_sym;

	assign tok_open  = (st.mode == MODE_NUM) || (st.mode == MODE_IDENT);
	assign needs_sym = (st.cls == CLS_SYMBOL) || (st.cls == CLS_OTHER) ||
		(st.cls == CLS_UNDER);

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		s_tready = 1'b0;
		case (state_q)
			ST_SCAN: begin
				s_tready = st.out_free;
				if (s_tvalid && st.out_free) begin
					if (st.act) begin
						if (tok_open) begin
							cmd.capture   = 1'b1;
							cmd.idx_clear = 1'b1;
							state_d       = ST_EMIT;
						end
					end else if (st.cls == CLS_NEWLINE) begin
						// drop: newline neither ends nor joins a token
					end else if (st.mode == MODE_NUM && st.lz && st.cls == CLS_DIGIT) begin
						cmd.clear = 1'b1;
						state_d   = ST_HALT;
					end else if ((st.mode == MODE_NUM && st.cls == CLS_DIGIT) ||
						(st.mode == MODE_IDENT && (st.cls == CLS_DIGIT ||
						st.cls == CLS_ALPHA || st.cls == CLS_UNDER))) begin
						cmd.append = 1'b1;
					end else if (tok_open) begin
						cmd.capture   = 1'b1;
						cmd.idx_clear = 1'b1;
						state_d       = ST_EMIT;
					end else if (st.cls == CLS_DIGIT) begin
						cmd.open_num = 1'b1;
						cmd.append   = 1'b1;
					end else if (st.cls == CLS_ALPHA) begin
						cmd.open_ident = 1'b1;
						cmd.append     = 1'b1;
					end else if (needs_sym) begin
						cmd.sym_load = 1'b1;
						cmd.run_last = 1'b1;
					end
				end
			end
			ST_EMIT: begin
				cmd.use_held = 1'b1;
				if (st.out_free) begin
					cmd.emit_load = 1'b1;
					cmd.run_last  = st.last_byte && (st.act || !needs_sym);
					if (st.last_byte) begin
						cmd.clear = 1'b1;
						state_d   = ST_SCAN;
						if (!st.act) begin
							if (st.cls == CLS_DIGIT) begin
								cmd.open_num = 1'b1;
								cmd.append   = 1'b1;
							end else if (st.cls == CLS_ALPHA) begin
								cmd.open_ident = 1'b1;
								cmd.append     = 1'b1;
							end else if (needs_sym) begin
								state_d = ST_SYM;
							end
						end
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			ST_SYM: begin
				cmd.use_held = 1'b1;
				if (st.out_free) begin
					cmd.sym_load = 1'b1;
					cmd.run_last = 1'b1;
					state_d      = ST_SCAN;
				end
			end
			ST_HALT: begin
				// swallow everything until reset
				s_tready = 1'b1;
			end
			default: begin
				state_d = ST_SCAN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SCAN;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HALT |=> state_q == ST_HALT)
		else $error("lexer left the halted state");

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_load || cmd.sym_load) |-> st.out_free)
		else $error("output loaded while occupied");

	a_sym_class: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SYM |-> (st.cls == CLS_SYMBOL || st.cls == CLS_OTHER ||
		st.cls == CLS_UNDER))
		else $error("one-byte token pending for a character that makes none");
`endif

endmodule
`default_nettype wire

@@ rtl/core/klex_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// klex_dp - lexer datapath
// Token text buffer, length and overflow tracking, keyword match, held input
// word, and the output register.
// ----------------------------------------------------------------------------
module klex_dp #(
	parameter int MAX_TOKEN_LEN = klex_pkg::MAX_TOKEN_LEN_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [7:0]     s_tdata,
	input  wire logic           s_tuser,
	input  wire logic           m_tready,
	output logic                m_tvalid,
	output logic [7:0]          m_tdata,
	output logic [4:0]          m_tuser,
	output logic                m_tlast,
	input  wire klex_pkg::cmd_t cmd,
	output klex_pkg::status_t   st
);
	import klex_pkg::*;

	localparam int IDX_W = $clog2(MAX_TOKEN_LEN);
	localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LEN);

	logic [7:0]       mem [MAX_TOKEN_LEN];
	logic [7:0]       rdata_q;
	logic [7:0]       char_q;
	logic             act_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] idx_d;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] base_len;
	logic             ovf_q;
	logic             lz_q;
	scan_mode_t       mode_q;
	logic             kw_if_q;
	logic             kw_else_q;
	logic             kw_while_q;
	logic [2:0]       pos;
	logic [7:0]       sel_char;
	logic             sel_act;
	char_class_t      cls;
	logic             wr_ok;
	logic             keyword;
	logic             last_byte;

	logic             out_valid_q;
	logic [2:0]       out_kind_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;
	logic             out_run_q;
	logic             out_cut_q;
	logic             out_free;

	assign sel_char  = cmd.use_held ? char_q : s_tdata;
	assign sel_act   = cmd.use_held ? act_q : s_tuser;
	assign cls       = klex_classify(sel_char);
	assign base_len  = cmd.clear ? '0 : len_q;
	assign wr_ok     = cmd.append && (base_len < LEN_MAX);
	assign pos       = (base_len < LEN_W'(6)) ? base_len[2:0] : 3'd7;
	assign last_byte = (LEN_W'(idx_q) + LEN_W'(1)) == len_q;
	assign keyword   = !ovf_q && ((kw_if_q && len_q == LEN_W'(2)) ||
		(kw_else_q && len_q == LEN_W'(4)) || (kw_while_q && len_q == LEN_W'(5)));
	assign out_free  = !out_valid_q || m_tready;

	always_comb begin
		if (cmd.idx_clear)
			idx_d = '0;
		else if (cmd.idx_inc)
			idx_d = idx_q + IDX_W'(1);
		else
			idx_d = idx_q;
	end

	// text buffer: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_ok)
			mem[base_len[IDX_W-1:0]] <= sel_char;
		rdata_q <= mem[idx_d];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			char_q <= s_tdata;
			act_q  <= s_tuser;
		end
		idx_q <= idx_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			ovf_q      <= 1'b0;
			lz_q       <= 1'b0;
			mode_q     <= MODE_IDLE;
			kw_if_q    <= 1'b0;
			kw_else_q  <= 1'b0;
			kw_while_q <= 1'b0;
		end else begin
			len_q <= wr_ok ? base_len + LEN_W'(1) : base_len;
			ovf_q <= (ovf_q && !cmd.clear) || (cmd.append && !wr_ok);
			if (cmd.open_num) begin
				mode_q <= MODE_NUM;
				lz_q   <= (sel_char == "0");
			end else if (cmd.open_ident) begin
				mode_q <= MODE_IDENT;
				lz_q   <= 1'b0;
			end else if (cmd.clear) begin
				mode_q <= MODE_IDLE;
				lz_q   <= 1'b0;
			end
			if (cmd.append) begin
				kw_if_q    <= (pos == 3'd0 || kw_if_q) && kw_if_at(pos, sel_char);
				kw_else_q  <= (pos == 3'd0 || kw_else_q) && kw_else_at(pos, sel_char);
				kw_while_q <= (pos == 3'd0 || kw_while_q) && kw_while_at(pos, sel_char);
			end else if (cmd.clear) begin
				kw_if_q    <= 1'b0;
				kw_else_q  <= 1'b0;
				kw_while_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_load || cmd.sym_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			out_kind_q <= (mode_q == MODE_NUM) ? KIND_NUM :
				(keyword ? KIND_KEYWORD : KIND_IDENT);
			out_byte_q <= rdata_q;
			out_last_q <= last_byte;
			out_run_q  <= cmd.run_last;
			out_cut_q  <= ovf_q;
		end else if (cmd.sym_load) begin
			out_kind_q <= (cls == CLS_SYMBOL) ? KIND_SYMBOL : KIND_INVALID;
			out_byte_q <= sel_char;
			out_last_q <= 1'b1;
			out_run_q  <= cmd.run_last;
			out_cut_q  <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_cut_q, out_run_q, out_kind_q};

	assign st.mode      = mode_q;
	assign st.act       = sel_act;
	assign st.cls       = cls;
	assign st.lz        = lz_q;
	assign st.last_byte = last_byte;
	assign st.out_free  = out_free;

`ifndef NO_ASSERTIONS
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_MAX)
		else $error("token length past buffer size");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> len_q == LEN_MAX)
		else $error("overflow flagged with room left");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_IDLE |-> len_q == '0)
		else $error("buffered text with no open token");

	a_lz_single: assert property (@(posedge clk) disable iff (!arst_n)
		lz_q |-> (mode_q == MODE_NUM && len_q == LEN_W'(1)))
		else $error("leading zero flag on a token other than a lone zero");
`endif

endmodule
`default_nettype wire
